[rtl/bhpq_pkg.sv]
// Package: shared types and constants for the binary heap priority queue.
package bhpq_pkg;
    localparam int Depth    = 1024;
    localparam int KeyWidth = 32;
    localparam int IdxW     = $clog2(Depth);
    localparam int CntW     = IdxW + 1;
    localparam int CfgIdxW  = 1;

    typedef logic [1:0]          t_op;
    typedef logic [1:0]          t_status;
    typedef logic [KeyWidth-1:0] t_key;
    typedef logic [IdxW-1:0]     t_idx;
    typedef logic [CntW-1:0]     t_cnt;

    localparam t_op OP_INSERT  = 2'd0;
    localparam t_op OP_EXTRACT = 2'd1;
    localparam t_op OP_UPDATE  = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_ORDER    = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_CAPACITY = 1'b1;

    // Classified command passed from front end to back end
    typedef struct packed {
        t_op  op;
        t_key key;
        t_idx idx;
    } t_cmd;

    // Result item
    typedef struct packed {
        t_status status;
        t_key    key_out;
        t_cnt    count_out;
        logic    is_empty;
        logic    is_full;
    } t_res;
endpackage

[rtl/bhpq_if.sv]
// Interfaces: request, result and configuration channels.
interface bhpq_req_if;
    logic              valid;
    logic              ready;
    bhpq_pkg::t_op     op;
    bhpq_pkg::t_key    key;
    bhpq_pkg::t_idx    index;
    modport source(output valid, op, key, index, input ready);
    modport sink(input valid, op, key, index, output ready);
endinterface

interface bhpq_res_if;
    logic              valid;
    logic              ready;
    bhpq_pkg::t_status status;
    bhpq_pkg::t_key    key_out;
    bhpq_pkg::t_cnt    count_out;
    logic              is_empty;
    logic              is_full;
    modport source(output valid, status, key_out, count_out, is_empty, is_full, input ready);
    modport sink(input valid, status, key_out, count_out, is_empty, is_full, output ready);
endinterface

interface bhpq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bhpq_pkg::CfgIdxW-1:0]   index;
    logic [10:0]                    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/bhpq_front.sv]
// Front end: two-entry request queue that decouples intake from the heap engine.
module bhpq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bhpq_pkg::t_cmd     i_in_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output bhpq_pkg::t_cmd     o_cmd
);
    bhpq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_in_cmd;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[rtl/bhpq_back.sv]
// Back end: heap engine with key memory, sift sequencer and result register.
module bhpq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_order,
    input  bhpq_pkg::t_cnt     i_cap,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  bhpq_pkg::t_cmd     i_cmd,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output bhpq_pkg::t_res     o_res,
    output logic               o_idle
);
    typedef enum logic [2:0] {
        S_IDLE, S_RD0, S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_DONE
    } t_state;

    localparam int Depth = bhpq_pkg::Depth;
    localparam int IdxW  = bhpq_pkg::IdxW;
    localparam int CntW  = bhpq_pkg::CntW;
    localparam int ChW   = CntW + 1;

    // key memory: one write port, two registered read ports
    bhpq_pkg::t_key mem [Depth];
    logic           we;
    bhpq_pkg::t_idx wa, ra0, ra1;
    bhpq_pkg::t_key wd, r_rd0, r_rd1;

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd0 <= mem[ra0];
        r_rd1 <= mem[ra1];
    end

    t_state          r_state;
    bhpq_pkg::t_cnt  r_count;
    bhpq_pkg::t_idx  r_pos;      // current hole position of the moving key
    bhpq_pkg::t_key  r_key;      // moving key
    bhpq_pkg::t_op   r_op;
    bhpq_pkg::t_res  r_res;
    logic            r_valid;

    bhpq_pkg::t_cnt  cap_eff;
    logic [ChW-1:0]  lch, rch;
    bhpq_pkg::t_idx  par;
    logic            up_go, l_ok, r_ok, go_l, go_r;
    bhpq_pkg::t_key  best;

    function automatic logic above(input logic ord, input bhpq_pkg::t_key a,
                                   input bhpq_pkg::t_key b);
        above = ord ? (a > b) : (a < b);
    endfunction

    assign cap_eff     = (i_cap > CntW'(Depth)) ? CntW'(Depth) : i_cap;
    assign lch         = {1'b0, r_pos, 1'b1};
    assign rch         = {1'b0, r_pos, 1'b0} + ChW'(2);
    assign par         = IdxW'((r_pos - IdxW'(1)) >> 1);
    assign o_cmd_ready = (r_state == S_IDLE) && (!r_valid || i_res_ready);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;
    assign o_idle      = (r_state == S_IDLE) && !r_valid;

    // up-step choice: parent data is in r_rd0
    assign up_go = (r_pos != '0) && above(i_order, r_key, r_rd0);

    // down-step choice: left child in r_rd0, right child in r_rd1
    always_comb begin
        l_ok = lch < {1'b0, r_count};
        r_ok = rch < {1'b0, r_count};
        best = r_key;
        go_l = 1'b0;
        go_r = 1'b0;
        if (l_ok && above(i_order, r_rd0, best)) begin
            best = r_rd0;
            go_l = 1'b1;
        end
        if (r_ok && above(i_order, r_rd1, best)) begin
            go_r = 1'b1;
            go_l = 1'b0;
        end
    end

    // memory addressing and writes per state
    always_comb begin
        we  = 1'b0;
        wa  = r_pos;
        wd  = r_key;
        ra0 = par;
        ra1 = IdxW'(rch);
        unique case (r_state)
            S_IDLE: begin
                ra0 = (i_cmd.op == bhpq_pkg::OP_UPDATE) ? i_cmd.idx : '0;
                ra1 = IdxW'(r_count - CntW'(1));
            end
            S_DNRD: begin
                ra0 = IdxW'(lch);
                ra1 = IdxW'(rch);
            end
            S_UPCMP: begin
                // parent moves down into the hole, or the key settles
                we = 1'b1;
                if (up_go) wd = r_rd0;
            end
            S_DNCMP: begin
                // better child moves up into the hole, or the key settles
                we = 1'b1;
                if (go_r) wd = r_rd1;
                else if (go_l) wd = r_rd0;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_valid && i_res_ready) r_valid <= 1'b0;
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_op          <= i_cmd.op;
                        r_key         <= i_cmd.key;
                        r_res.key_out <= '0;
                        case (i_cmd.op)
                            bhpq_pkg::OP_INSERT: begin
                                if (r_count >= cap_eff) begin
                                    r_res.status <= bhpq_pkg::ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= bhpq_pkg::ST_OK;
                                    r_pos        <= IdxW'(r_count);
                                    r_count      <= r_count + CntW'(1);
                                    r_state      <= S_UPRD;
                                end
                            end
                            bhpq_pkg::OP_EXTRACT: begin
                                if (r_count == '0) begin
                                    r_res.status <= bhpq_pkg::ST_EMPTY;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= bhpq_pkg::ST_OK;
                                    r_pos        <= '0;
                                    r_count      <= r_count - CntW'(1);
                                    r_state      <= S_RD0;
                                end
                            end
                            bhpq_pkg::OP_UPDATE: begin
                                if (CntW'(i_cmd.idx) >= r_count) begin
                                    r_res.status <= bhpq_pkg::ST_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= bhpq_pkg::ST_OK;
                                    r_pos        <= i_cmd.idx;
                                    r_state      <= S_RD0;
                                end
                            end
                            default: begin
                                r_res.status <= bhpq_pkg::ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD0: begin
                    // r_rd0: root or old key; r_rd1: last entry
                    r_res.key_out <= r_rd0;
                    if (r_op == bhpq_pkg::OP_EXTRACT) begin
                        r_key   <= r_rd1;
                        r_state <= (r_count == '0) ? S_DONE : S_DNRD;
                    end else begin
                        r_state <= above(i_order, r_key, r_rd0) ? S_UPRD : S_DNRD;
                    end
                end
                S_UPRD:  r_state <= S_UPCMP;
                S_UPCMP: begin
                    if (up_go) begin
                        r_pos   <= par;
                        r_state <= S_UPRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DNRD:  r_state <= S_DNCMP;
                S_DNCMP: begin
                    if (go_r) begin
                        r_pos   <= IdxW'(rch);
                        r_state <= S_DNRD;
                    end else if (go_l) begin
                        r_pos   <= IdxW'(lch);
                        r_state <= S_DNRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_res.count_out <= r_count;
                    r_res.is_empty  <= (r_count == '0);
                    r_res.is_full   <= (r_count >= cap_eff);
                    r_valid         <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/binary_heap_priority_queue_core.sv]
// Top level: binary heap priority queue with decoupled intake and heap engine.
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    op, key, index
//  o_res     out  valid/ready    status, key_out, count_out, is_empty, is_full
//  i_cfg     in   valid/ready    index, data
// A request is registered in the queue before the engine takes it; a refused or ignored
// request goes straight to its result, and insert, extract and update sift level by level.
// Each sift level is a registered key read, then a compare and one write.
// Reset is synchronous active low; it empties the heap, sets min order and capacity 1024.
// The key memory has no clearing pass. Requests queue two deep while the engine works;
// a result held by the sink stalls the engine, then the queue.
module binary_heap_priority_queue_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhpq_req_if.sink   i_req,
    bhpq_res_if.source o_res,
    bhpq_cfg_if.sink   i_cfg
);
    logic           r_order;
    bhpq_pkg::t_cnt r_cap;
    logic           cmd_valid, cmd_ready, idle;
    bhpq_pkg::t_cmd in_cmd, cmd;
    bhpq_pkg::t_res res;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_cap   <= bhpq_pkg::CntW'(bhpq_pkg::Depth);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bhpq_pkg::REG_ORDER:    r_order <= i_cfg.data[0];
                bhpq_pkg::REG_CAPACITY: r_cap   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign in_cmd = '{op: i_req.op, key: i_req.key, idx: i_req.index};

    bhpq_front u_front (
        .i_clk, .i_rst_n,
        .i_in_valid (i_req.valid), .o_in_ready (i_req.ready), .i_in_cmd (in_cmd),
        .o_cmd_valid (cmd_valid), .i_cmd_ready (cmd_ready), .o_cmd (cmd)
    );

    bhpq_back u_back (
        .i_clk, .i_rst_n, .i_order (r_order), .i_cap (r_cap),
        .i_cmd_valid (cmd_valid), .o_cmd_ready (cmd_ready), .i_cmd (cmd),
        .o_res_valid (o_res.valid), .i_res_ready (o_res.ready), .o_res (res),
        .o_idle (idle)
    );

    assign o_res.status    = res.status;
    assign o_res.key_out   = res.key_out;
    assign o_res.count_out = res.count_out;
    assign o_res.is_empty  = res.is_empty;
    assign o_res.is_full   = res.is_full;

    // empty flag agrees with the count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.is_empty == (o_res.count_out == '0)))
        else $error("empty flag mismatch");
    // full and range refusals return a zero key
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status == bhpq_pkg::ST_FULL ||
        o_res.status == bhpq_pkg::ST_RANGE) |-> (o_res.key_out == '0))
        else $error("refused request returned a key");
    // count never exceeds store depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.count_out <= bhpq_pkg::CntW'(bhpq_pkg::Depth)))
        else $error("count past depth");
    // idle engine never shows a result as pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle |-> !o_res.valid)
        else $error("idle with pending result");
endmodule

[sim/binary_heap_priority_queue_core_tb.sv]
// Testbench: heap priority queue checked against a behavioral heap, directed then random.
module binary_heap_priority_queue_core_tb;
    localparam bhpq_pkg::t_op OP_IGNORED = 2'd3;
    localparam int  SettleCycles = 60;

    logic i_clk;
    logic i_rst_n;

    bhpq_req_if req_ch();
    bhpq_res_if res_ch();
    bhpq_cfg_if cfg_ch();

    binary_heap_priority_queue_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Behavioral heap and its register copies
    bhpq_pkg::t_key heap_keys [bhpq_pkg::Depth];
    int             heap_count;
    logic           max_order;
    logic [10:0]    cap_reg;

    bhpq_pkg::t_res pending_res [$];
    int             fail_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int cap_limit();
        return (cap_reg > bhpq_pkg::Depth) ? bhpq_pkg::Depth : int'(cap_reg);
    endfunction

    function automatic bit outranks(bhpq_pkg::t_key a, bhpq_pkg::t_key b);
        return max_order ? (a > b) : (a < b);
    endfunction

    function automatic void swap_keys(int a, int b);
        bhpq_pkg::t_key t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!outranks(heap_keys[i], heap_keys[p])) break;
            swap_keys(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int l, r, best;
        forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            if (l < heap_count && outranks(heap_keys[l], heap_keys[best])) best = l;
            if (r < heap_count && outranks(heap_keys[r], heap_keys[best])) best = r;
            if (best == i) break;
            swap_keys(i, best);
            i = best;
        end
    endfunction

    // Apply one request to the heap and return the result it should produce
    function automatic bhpq_pkg::t_res heap_apply(bhpq_pkg::t_op op, bhpq_pkg::t_key key,
                                                  bhpq_pkg::t_idx idx);
        bhpq_pkg::t_res r;
        bhpq_pkg::t_key old;
        r = '0;
        case (op)
            bhpq_pkg::OP_INSERT: begin
                if (heap_count >= cap_limit()) begin
                    r.status = bhpq_pkg::ST_FULL;
                end else begin
                    heap_keys[heap_count] = key;
                    bubble_up(heap_count);
                    heap_count++;
                end
            end
            bhpq_pkg::OP_EXTRACT: begin
                if (heap_count == 0) begin
                    r.status = bhpq_pkg::ST_EMPTY;
                end else begin
                    r.key_out = heap_keys[0];
                    heap_count--;
                    heap_keys[0] = heap_keys[heap_count];
                    bubble_down(0);
                end
            end
            bhpq_pkg::OP_UPDATE: begin
                if (int'(idx) >= heap_count) begin
                    r.status = bhpq_pkg::ST_RANGE;
                end else begin
                    old = heap_keys[idx];
                    r.key_out = old;
                    heap_keys[idx] = key;
                    if (outranks(key, old)) bubble_up(idx);
                    else bubble_down(idx);
                end
            end
            default: ;
        endcase
        r.count_out = bhpq_pkg::t_cnt'(heap_count);
        r.is_empty  = (heap_count == 0);
        r.is_full   = (heap_count >= cap_limit());
        return r;
    endfunction

    // Send one request; the expectation is queued at the accepting edge
    task automatic send_req(bhpq_pkg::t_op op, bhpq_pkg::t_key key, bhpq_pkg::t_idx idx,
                            output bhpq_pkg::t_res predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        req_ch.index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = heap_apply(op, key, idx);
        pending_res.push_back(predicted);
        @(negedge i_clk);
    endtask

    // Wait until all results are back and the engine has settled
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [bhpq_pkg::CfgIdxW-1:0] idx, logic [10:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == bhpq_pkg::REG_ORDER) max_order = data[0];
        else cap_reg = data;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random request mix; keys often small so equal keys show up
    task automatic random_run(int n, int insert_pct);
        bhpq_pkg::t_op  op;
        bhpq_pkg::t_key key;
        bhpq_pkg::t_idx idx;
        bhpq_pkg::t_res dummy;
        int             r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < insert_pct) op = bhpq_pkg::OP_INSERT;
            else if (r < insert_pct + (97 - insert_pct) / 2) op = bhpq_pkg::OP_EXTRACT;
            else if (r < 97) op = bhpq_pkg::OP_UPDATE;
            else op = OP_IGNORED;
            key = $urandom_range(1) ? bhpq_pkg::t_key'($urandom)
                                    : bhpq_pkg::t_key'($urandom_range(15));
            if ($urandom_range(9) == 0 || heap_count == 0) idx = bhpq_pkg::t_idx'($urandom);
            else idx = bhpq_pkg::t_idx'($urandom_range(heap_count));
            send_req(op, key, idx, dummy);
        end
    endtask

    // Result receiver with random stalls and one long hold-off
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result: status %0d key_out %h", res_ch.status, res_ch.key_out);
                fail_count++;
            end else begin
                bhpq_pkg::t_res e;
                e = pending_res.pop_front();
                if (res_ch.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.key_out !== e.key_out) begin
                    $error("key_out: expected %h, got %h", e.key_out, res_ch.key_out);
                    fail_count++;
                end
                if (res_ch.count_out !== e.count_out) begin
                    $error("count_out: expected %0d, got %0d", e.count_out, res_ch.count_out);
                    fail_count++;
                end
                if (res_ch.is_empty !== e.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", e.is_empty, res_ch.is_empty);
                    fail_count++;
                end
                if (res_ch.is_full !== e.is_full) begin
                    $error("is_full: expected %0d, got %0d", e.is_full, res_ch.is_full);
                    fail_count++;
                end
            end
        end
    end

    // Directed requests; fixed results only where obvious
    typedef struct {
        bhpq_pkg::t_op  op;
        bhpq_pkg::t_key key;
        bhpq_pkg::t_idx idx;
        bit             fixed;
        bhpq_pkg::t_res res;
    } t_row;

    t_row directed_rows [19] = '{
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 1,
          '{bhpq_pkg::ST_EMPTY, 32'h0, 11'd0, 1'b1, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'h1234, 10'd0, 1,
          '{bhpq_pkg::ST_RANGE, 32'h0, 11'd0, 1'b1, 1'b0}},
        '{OP_IGNORED, 32'hFFFFFFFF, 10'd1023, 1,
          '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b1, 1'b0}},
        '{bhpq_pkg::OP_INSERT, 32'hFFFFFFFF, 10'd0, 1,
          '{bhpq_pkg::ST_OK, 32'h0, 11'd1, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_INSERT, 32'h0, 10'd0, 1,
          '{bhpq_pkg::ST_OK, 32'h0, 11'd2, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_INSERT, 32'h5, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_INSERT, 32'h5, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_INSERT, 32'h80000000, 10'd0, 0,
          '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'h7, 10'd1023, 1,
          '{bhpq_pkg::ST_RANGE, 32'h0, 11'd5, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'h7, 10'd5, 1,
          '{bhpq_pkg::ST_RANGE, 32'h0, 11'd5, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'hAAAA5555, 10'd0, 0,
          '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'h0, 10'd4, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_UPDATE, 32'h5, 10'd2, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 0, '{bhpq_pkg::ST_OK, 32'h0, 11'd0, 1'b0, 1'b0}},
        '{bhpq_pkg::OP_EXTRACT, 32'h0, 10'd0, 1,
          '{bhpq_pkg::ST_EMPTY, 32'h0, 11'd0, 1'b1, 1'b0}}
    };

    // Main sequence
    initial begin
        bhpq_pkg::t_res got;
        fail_count    = 0;
        heap_count    = 0;
        max_order     = 1'b0;
        cap_reg       = 11'd1024;
        hold_req      = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 63;
        req_ch.valid  = 1'b0;
        req_ch.op     = bhpq_pkg::OP_INSERT;
        req_ch.key    = '0;
        req_ch.index  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = bhpq_pkg::REG_ORDER;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at reset settings
        foreach (directed_rows[i]) begin
            send_req(directed_rows[i].op, directed_rows[i].key, directed_rows[i].idx, got);
            if (directed_rows[i].fixed && got !== directed_rows[i].res) begin
                $error("directed row %0d: table result differs from heap prediction", i);
                fail_count++;
            end
        end
        random_run(200, 50);
        drain();

        // Max order, tiny capacity so full refusals are common
        write_reg(bhpq_pkg::REG_ORDER, 11'd1);
        write_reg(bhpq_pkg::REG_CAPACITY, 11'd5);
        random_run(150, 55);
        drain();

        // Capacity of one, then zero
        write_reg(bhpq_pkg::REG_CAPACITY, 11'd1);
        random_run(10, 60);
        drain();
        write_reg(bhpq_pkg::REG_CAPACITY, 11'd0);
        random_run(10, 60);
        drain();

        // Swap idling roles, min order, capacity beyond the store
        send_idle_pct = 63;
        recv_idle_pct = 10;
        write_reg(bhpq_pkg::REG_ORDER, 11'd0);
        write_reg(bhpq_pkg::REG_CAPACITY, 11'h7FF);
        random_run(250, 65);
        drain();

        // No idling, long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(bhpq_pkg::REG_ORDER, 11'd1);
        hold_req = 1'b1;
        random_run(500, 45);
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
